>>> rtl/core/sha_pkg.sv
// SHA-256 package: round constants, initial hash values, helper functions
// and the request type passed from the byte front end to the compression core.
// No dependencies.
package sha_pkg;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam int unsigned LenPos = 56;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned CountWidth = 61;
    localparam int unsigned QueueDepth = 2;

    typedef logic [31:0] word_t;
    typedef word_t [15:0] block_t;
    typedef word_t [7:0] chain_t;

    // One compression request: a full block, and whether it closes the message.
    typedef struct packed {
        block_t block;
        logic   final_blk;
    } comp_req_t;

    typedef enum logic [1:0] {
        CORE_IDLE,
        CORE_ROUND,
        CORE_ADD
    } core_state_t;

    typedef enum logic [1:0] {
        FE_COLLECT,
        FE_PAD_FIRST,
        FE_PAD_SECOND
    } fe_state_t;

    function automatic word_t ror32(input word_t x, input int unsigned n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

endpackage

>>> rtl/core/sha_front.sv
// Byte front end: packs bytes into 64-byte blocks, appends padding and the
// bit length, and issues compression requests. Depends on sha_pkg.
module sha_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              has_byte,
    input  logic              last,
    output sha_pkg::comp_req_t req,
    output logic              req_valid,
    input  logic              req_ready
);
    import sha_pkg::*;

    fe_state_t              state_reg, state_next;
    block_t                 block_reg, block_next;
    logic [CountWidth-1:0]  count_reg, count_next;
    logic                   pend_reg, pend_next;
    logic                   pend_final_reg, pend_final_next;
    logic                   accept;
    logic [5:0]             pos;
    logic [63:0]            bit_len;

    assign full = (state_reg != FE_COLLECT) || pend_reg;
    assign accept = push && !full;
    assign req_valid = pend_reg;
    assign req.block = block_reg;
    assign req.final_blk = pend_final_reg;
    assign bit_len = {count_reg, 3'b000};

    always_comb
    begin
        state_next = state_reg;
        block_next = block_reg;
        count_next = count_reg;
        pend_next = pend_reg;
        pend_final_next = pend_final_reg;
        pos = count_reg[5:0];
        if (pend_reg && req_ready)
        begin
            pend_next = 1'b0;
            if (pend_final_reg)
            begin
                count_next = '0;
            end
        end
        unique case (state_reg)
            FE_COLLECT:
            begin
                if (accept)
                begin
                    if (has_byte)
                    begin
                        block_next[pos[5:2]][8*(3-pos[1:0]) +: 8] = data_byte;
                        count_next = count_reg + 1'b1;
                        if (pos == 6'd63)
                        begin
                            pend_next = 1'b1;
                            pend_final_next = 1'b0;
                        end
                    end
                    if (last)
                    begin
                        state_next = FE_PAD_FIRST;
                    end
                end
            end
            FE_PAD_FIRST:
            begin
                // Pad the block being filled; spill to a second block if
                // the length does not fit behind the pad byte.
                if (!pend_reg)
                begin
                    for (int b = 0; b < BlockBytes; b++)
                    begin
                        if (b == int'(pos))
                        begin
                            block_next[b/4][8*(3-(b%4)) +: 8] = PadByte;
                        end
                        else if (b > int'(pos))
                        begin
                            block_next[b/4][8*(3-(b%4)) +: 8] = 8'h00;
                        end
                    end
                    pend_next = 1'b1;
                    if (int'(pos) >= LenPos)
                    begin
                        pend_final_next = 1'b0;
                        state_next = FE_PAD_SECOND;
                    end
                    else
                    begin
                        block_next[14] = bit_len[63:32];
                        block_next[15] = bit_len[31:0];
                        pend_final_next = 1'b1;
                        state_next = FE_COLLECT;
                    end
                end
            end
            FE_PAD_SECOND:
            begin
                if (!pend_reg)
                begin
                    block_next = '0;
                    block_next[14] = bit_len[63:32];
                    block_next[15] = bit_len[31:0];
                    pend_next = 1'b1;
                    pend_final_next = 1'b1;
                    state_next = FE_COLLECT;
                end
            end
            default:
            begin
                state_next = FE_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_COLLECT;
            count_reg <= '0;
            pend_reg <= 1'b0;
            pend_final_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg <= pend_next;
            pend_final_reg <= pend_final_next;
        end
    end

    always_ff @(posedge clk)
    begin
        block_reg <= block_next;
    end

endmodule

>>> rtl/core/sha_queue.sv
// Short request queue between the front end and the compression core.
// Depends on sha_pkg.
module sha_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::comp_req_t in_req,
    input  logic              in_valid,
    output logic              in_ready,
    output sha_pkg::comp_req_t out_req,
    output logic              out_valid,
    input  logic              out_ready
);
    import sha_pkg::*;

    comp_req_t  mem [QueueDepth];
    logic [0:0] wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       wr_en, rd_en;

    assign in_ready = cnt_reg != 2'(QueueDepth);
    assign out_valid = cnt_reg != 2'd0;
    assign wr_en = in_valid && in_ready;
    assign rd_en = out_valid && out_ready;
    assign out_req = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= in_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {1'b0, wr_en} - {1'b0, rd_en};
        end
    end

endmodule

>>> rtl/core/sha_core.sv
// Compression core: one SHA-256 round per cycle with a rolling 16-word
// schedule window, and a one-entry result register. Depends on sha_pkg.
module sha_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sha_pkg::comp_req_t req,
    input  logic              req_valid,
    output logic              req_ready,
    output sha_pkg::chain_t   digest,
    output logic              empty,
    input  logic              pop
);
    import sha_pkg::*;

    core_state_t state_reg, state_next;
    chain_t      chain_reg;
    chain_t      v_reg, v_next;
    block_t      w_reg, w_next;
    logic [5:0]  round_reg;
    logic        final_reg;
    chain_t      out_reg;
    logic        out_valid_reg;
    word_t       wt, s1, ch, t1, s0, mj, sg0, sg1;

    assign digest = out_reg;
    assign empty = !out_valid_reg;
    // A closing block waits until the result register is free.
    assign req_ready = (state_reg == CORE_IDLE) &&
                       (!req.final_blk || !out_valid_reg || pop);

    always_comb
    begin
        sg0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
        sg1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
        wt = w_reg[0];
        s1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
        ch = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1 = v_reg[7] + s1 + ch + RoundK[round_reg] + wt;
        s0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
        mj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        v_next = v_reg;
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + s0 + mj;
        // Window shifts down; the new word is W[t+16].
        for (int i = 0; i < 15; i++)
        begin
            w_next[i] = w_reg[i+1];
        end
        w_next[15] = w_reg[0] + sg0 + w_reg[9] + sg1;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CORE_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = CORE_ADD;
                end
            end
            CORE_ADD:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            round_reg <= '0;
            final_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= InitH[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                CORE_IDLE:
                begin
                    round_reg <= '0;
                    if (req_valid && req_ready)
                    begin
                        final_reg <= req.final_blk;
                    end
                end
                CORE_ROUND:
                begin
                    round_reg <= round_reg + 1'b1;
                end
                CORE_ADD:
                begin
                    if (final_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_reg[i] <= InitH[i];
                        end
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            chain_reg[i] <= chain_reg[i] + v_reg[i];
                        end
                    end
                end
                default:
                begin
                    round_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            CORE_IDLE:
            begin
                v_reg <= chain_reg;
                w_reg <= req.block;
            end
            CORE_ROUND:
            begin
                v_reg <= v_next;
                w_reg <= w_next;
            end
            CORE_ADD:
            begin
                // Only a closing block writes the digest, and only after the previous one was popped.
                if (final_reg)
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        out_reg[i] <= chain_reg[i] + v_reg[i];
                    end
                end
            end
            default:
            begin
                v_reg <= v_reg;
            end
        endcase
    end

endmodule

>>> rtl/core/sha256_message_digest_unit.sv
// Top level of the SHA-256 digest unit: byte front end, request queue and
// compression core. Depends on sha_pkg, sha_front, sha_queue and sha_core.
//
//  Channel   Handshake      Payload
//  input     push / full    data_byte, has_byte, last
//  result    pop / empty    digest_word_0 .. digest_word_7
//
// A byte is taken on each push while full is low. The core handles each
// 64-byte block in a load step, 64 rounds and a final add; a two-entry queue
// lets the front end fill the next block meanwhile. Padding adds one or two
// blocks at the end of a message.
// Reset is asynchronous and active low. full is high while a block waits
// to enter the queue or padding is being built; an unread digest stalls the
// core only when the next closing block is ready.
module sha256_message_digest_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word_0,
    output logic [31:0] digest_word_1,
    output logic [31:0] digest_word_2,
    output logic [31:0] digest_word_3,
    output logic [31:0] digest_word_4,
    output logic [31:0] digest_word_5,
    output logic [31:0] digest_word_6,
    output logic [31:0] digest_word_7
);
    import sha_pkg::*;

    comp_req_t fe_req, q_req;
    logic      fe_valid, fe_ready, q_valid, q_ready;
    chain_t    digest;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .last      (last),
        .req       (fe_req),
        .req_valid (fe_valid),
        .req_ready (fe_ready)
    );

    sha_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_req    (fe_req),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .out_req   (q_req),
        .out_valid (q_valid),
        .out_ready (q_ready)
    );

    sha_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (q_req),
        .req_valid (q_valid),
        .req_ready (q_ready),
        .digest    (digest),
        .empty     (empty),
        .pop       (pop)
    );

    assign digest_word_0 = digest[0];
    assign digest_word_1 = digest[1];
    assign digest_word_2 = digest[2];
    assign digest_word_3 = digest[3];
    assign digest_word_4 = digest[4];
    assign digest_word_5 = digest[5];
    assign digest_word_6 = digest[6];
    assign digest_word_7 = digest[7];

endmodule

>>> verif/sha256_message_digest_unit_test.sv
// Testbench for sha256_message_digest_unit: streams byte messages, predicts
// each SHA-256 digest with a behavioral hash model and checks every result.
// Depends on sha_pkg and the RTL of the digest unit.
`timescale 1ns / 1ps

module sha256_message_digest_unit_test;
    import sha_pkg::*;

    typedef struct {
        logic [31:0] w [8];
    } digest_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic        empty;
    logic        pop;
    logic [31:0] digest_word_0;
    logic [31:0] digest_word_1;
    logic [31:0] digest_word_2;
    logic [31:0] digest_word_3;
    logic [31:0] digest_word_4;
    logic [31:0] digest_word_5;
    logic [31:0] digest_word_6;
    logic [31:0] digest_word_7;

    // Hash model state
    logic [31:0] hash_state [8];
    logic [31:0] msg_words [16];
    logic [60:0] byte_total;
    digest_t     pending_digests [$];

    int  error_count;
    int  cycle_count;
    bit  drain_busy;

    sha256_message_digest_unit u_top (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_byte(data_byte), .has_byte(has_byte), .last(last),
        .empty(empty), .pop(pop),
        .digest_word_0(digest_word_0), .digest_word_1(digest_word_1),
        .digest_word_2(digest_word_2), .digest_word_3(digest_word_3),
        .digest_word_4(digest_word_4), .digest_word_5(digest_word_5),
        .digest_word_6(digest_word_6), .digest_word_7(digest_word_7)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_reset();
        hash_state = InitH;
        for (int i = 0; i < 16; i++)
        begin
            msg_words[i] = '0;
        end
        byte_total = '0;
    endtask

    task automatic hash_compress();
        logic [31:0] sched [16];
        logic [31:0] v [8];
        logic [31:0] w, x15, x2, t1, t2;
        sched = msg_words;
        v = hash_state;
        for (int r = 0; r < 64; r++)
        begin
            if (r < 16)
            begin
                w = sched[r];
            end
            else
            begin
                x15 = sched[(r - 15) & 15];
                x2 = sched[(r - 2) & 15];
                w = sched[r & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                    + sched[(r - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                sched[r & 15] = w;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[r] + w;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hash_state[i] += v[i];
        end
    endtask

    task automatic place_byte(input int pos, input logic [7:0] b);
        int sh;
        sh = (3 - (pos & 3)) * 8;
        msg_words[pos >> 2] = (msg_words[pos >> 2] & ~(32'hff << sh)) | (32'(b) << sh);
    endtask

    task automatic hash_absorb(input logic [7:0] b, input bit has, input bit fin);
        int pos;
        logic [63:0] bits;
        digest_t d;
        if (has)
        begin
            pos = int'(byte_total[5:0]);
            place_byte(pos, b);
            byte_total = byte_total + 1;
            if (pos == 63)
            begin
                hash_compress();
            end
        end
        if (fin)
        begin
            pos = int'(byte_total[5:0]);
            place_byte(pos, PadByte);
            for (int i = pos + 1; i < 64; i++)
            begin
                place_byte(i, 8'h00);
            end
            if (pos >= LenPos)
            begin
                hash_compress();
                for (int i = 0; i < 16; i++)
                begin
                    msg_words[i] = '0;
                end
            end
            bits = {byte_total, 3'b000};
            msg_words[14] = bits[63:32];
            msg_words[15] = bits[31:0];
            hash_compress();
            d.w = hash_state;
            pending_digests.insert(pending_digests.size(), d);
            hash_reset();
        end
    endtask

    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 90);
    endfunction

    // Sends one request and waits until it is accepted. push stays high
    // after acceptance so that a request with no gap follows directly.
    task automatic send_byte(input logic [7:0] b, input bit has, input bit fin);
        int gap;
        gap = drain_busy ? 0 : gap_length();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap)
            begin
                @(posedge clk);
            end
        end
        push <= 1'b1;
        data_byte <= b;
        has_byte <= has;
        last <= fin;
        do
        begin
            @(posedge clk);
        end while (full);
        hash_absorb(b, has, fin);
    endtask

    task automatic send_message(input int len, input bit empty_close);
        for (int i = 0; i < len; i++)
        begin
            send_byte(8'($urandom), 1'b1, (i == len - 1) && !empty_close);
        end
        if (empty_close || len == 0)
        begin
            send_byte(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic test_empty_message();
        send_byte(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_byte_extremes();
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h55, 1'b0, 1'b0);
        send_byte(8'haa, 1'b1, 1'b1);
    endtask

    task automatic test_padding_boundaries();
        int lens [6] = '{55, 56, 63, 64, 119, 120};
        foreach (lens[i])
        begin
            send_message(lens[i], i[0]);
        end
    endtask

    task automatic test_random_messages();
        int sent;
        int len;
        int p;
        sent = 0;
        while (sent < 1000)
        begin
            p = $urandom_range(0, 99);
            if (p < 60) len = $urandom_range(0, 20);
            else if (p < 90) len = $urandom_range(50, 70);
            else len = $urandom_range(100, 140);
            // Stray no-byte items between bytes are ignored by the block.
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_byte(8'($urandom), 1'b0, 1'b0);
                end
                send_byte(8'($urandom), 1'b1, (i == len - 1) && p[0]);
            end
            if (len == 0 || !p[0])
            begin
                send_byte(8'($urandom), 1'b0, 1'b1);
            end
            sent += len + 1;
        end
    endtask

    task automatic test_back_to_back();
        drain_busy = 1'b1;
        for (int m = 0; m < 6; m++)
        begin
            send_message($urandom_range(0, 70), 1'b0);
        end
        drain_busy = 1'b0;
    endtask

    // Result side: random pop stalls, each accepted digest checked in order.
    always @(posedge clk)
    begin
        digest_t d;
        logic [31:0] got [8];
        if (rst_n && pop && !empty)
        begin
            got = '{digest_word_0, digest_word_1, digest_word_2, digest_word_3,
                    digest_word_4, digest_word_5, digest_word_6, digest_word_7};
            if (pending_digests.size() == 0)
            begin
                $error("unexpected digest %h", digest_word_0);
                error_count++;
            end
            else
            begin
                d = pending_digests.pop_front();
                for (int i = 0; i < 8; i++)
                begin
                    if (got[i] !== d.w[i])
                    begin
                        $error("digest_word_%0d expected %h actual %h", i, d.w[i], got[i]);
                        error_count++;
                    end
                end
            end
        end
    end

    int pop_hold;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
            pop_hold <= 0;
        end
        else if (pop_hold > 0)
        begin
            pop_hold <= pop_hold - 1;
            pop <= 1'b0;
        end
        else if (!drain_busy && $urandom_range(0, 3) == 0)
        begin
            pop_hold <= gap_length();
            pop <= 1'b0;
        end
        else
        begin
            pop <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000)
        begin
            $display("sha256_message_digest_unit_test: errors");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        drain_busy = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        data_byte = '0;
        has_byte = 1'b0;
        last = 1'b0;
        hash_reset();
        repeat (6)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_message();
        test_byte_extremes();
        test_padding_boundaries();
        test_back_to_back();
        test_random_messages();
        push <= 1'b0;
        while (pending_digests.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (300)
        begin
            @(posedge clk);
        end
        if (error_count == 0)
        begin
            $display("sha256_message_digest_unit_test: clean");
        end
        else
        begin
            $display("sha256_message_digest_unit_test: errors");
        end
        $finish;
    end

endmodule
